// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion helpers shared by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property checked on every rising edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property checked on every rising edge, reset included
`define ASSERT_CLK_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_CLK_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== rtl/xbps_pkg.sv =====
// ----------------------------------------------------------------------------
// xbps_pkg
// shared types, constants and pattern match helpers of the body screen
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package xbps_pkg;

    localparam int LENGTH_MAX = 1048576;

    localparam int BYTE_W   = 8;
    localparam int LIMIT_W  = 21;
    localparam int TEXT_W   = 21;
    localparam int CNT_W    = $clog2(LENGTH_MAX + 2);
    localparam int CMP_W    = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

    localparam int WIN_DEPTH = 10;
    localparam int PAT_MAX   = WIN_DEPTH + 1;
    localparam int PAT_BITS  = PAT_MAX * BYTE_W;
    localparam int PLEN_W    = $clog2(PAT_MAX + 1);

    localparam int MARK_N   = 4;
    localparam int DANGER_N = 9;
    localparam int IDX_W    = 4;

    localparam int Q_DEPTH = 2;
    localparam int QPTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    localparam logic [1:0] VERDICT_OK        = 2'd0;
    localparam logic [1:0] VERDICT_TOO_LONG  = 2'd1;
    localparam logic [1:0] VERDICT_NO_MARKER = 2'd2;
    localparam logic [1:0] VERDICT_DANGER    = 2'd3;

    // patterns right aligned: last character in the low byte
    localparam logic [PAT_BITS-1:0] MARK_PAT [MARK_N] = '{
        PAT_BITS'("<?xml"),
        PAT_BITS'("<soap:"),
        PAT_BITS'("<s:Envelope"),
        PAT_BITS'("<soapenv:")
    };
    localparam logic [PLEN_W-1:0] MARK_LEN [MARK_N] = '{
        PLEN_W'(5), PLEN_W'(6), PLEN_W'(11), PLEN_W'(9)
    };

    localparam logic [PAT_BITS-1:0] DANGER_PAT [DANGER_N] = '{
        PAT_BITS'("<script"),
        PAT_BITS'("javascript:"),
        PAT_BITS'("vbscript:"),
        PAT_BITS'("onload="),
        PAT_BITS'("onerror="),
        PAT_BITS'("onclick="),
        PAT_BITS'("eval("),
        PAT_BITS'("exec("),
        PAT_BITS'("system(")
    };
    localparam logic [PLEN_W-1:0] DANGER_LEN [DANGER_N] = '{
        PLEN_W'(7), PLEN_W'(11), PLEN_W'(9), PLEN_W'(7), PLEN_W'(8),
        PLEN_W'(8), PLEN_W'(5), PLEN_W'(5), PLEN_W'(7)
    };

    typedef logic [WIN_DEPTH-1:0][BYTE_W-1:0] win_t;

    typedef struct packed {
        logic [CNT_W-1:0]    count;
        logic [CNT_W-1:0]    limit;
        logic                marker_any;
        logic [DANGER_N-1:0] danger;
    } rec_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic [BYTE_W-1:0] fold_lower(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] r;
        r = c;
        if (c inside {[8'h41:8'h5a]})
        begin
            r = c + 8'h20;
        end
        return r;
    endfunction

    // does the pattern end at the newest byte
    function automatic logic tail_hit(
        input win_t                win,
        input logic [BYTE_W-1:0]   newest,
        input logic [PAT_BITS-1:0] pat,
        input logic [PLEN_W-1:0]   plen,
        input logic                fold
    );
        logic              hit;
        logic [BYTE_W-1:0] c;
        hit = 1'b1;
        for (int k = 0; k < PAT_MAX; k++)
        begin
            c = (k == 0) ? newest : win[k-1];
            if (fold)
            begin
                c = fold_lower(c);
            end
            if ((PLEN_W'(k) < plen) && (c != pat[k*BYTE_W +: BYTE_W]))
            begin
                hit = 1'b0;
            end
        end
        return hit;
    endfunction

endpackage

// ===== rtl/xbps_front.sv =====
// ----------------------------------------------------------------------------
// xbps_front
// per-byte text state: history window, length count and pattern flags
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xbps_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_ready,
    input  logic [xbps_pkg::BYTE_W-1:0]       text_byte,
    input  logic                              byte_present,
    input  logic [xbps_pkg::LIMIT_W-1:0]      length_limit,
    input  logic                              last_item,
    input  xbps_pkg::q_stat_t                 q_stat,
    output logic                              push,
    output xbps_pkg::rec_t                    push_rec
);
    import xbps_pkg::*;

    win_t                win_reg,    win_next,    win_base;
    logic [MARK_N-1:0]   marker_reg, marker_next, marker_base;
    logic [DANGER_N-1:0] danger_reg, danger_next, danger_base;
    logic [CNT_W-1:0]    count_reg,  count_next,  count_base;
    logic                ended_reg,  ended_next,  ended_base;
    logic [CNT_W-1:0]    limit_reg,  limit_next,  limit_base;
    logic                start_reg,  start_next;

    logic [MARK_N-1:0]   mark_hit;
    logic [DANGER_N-1:0] danger_hit;
    logic [CMP_W-1:0]    limit_ext;
    logic                accept;

    assign item_ready = !q_stat.full;
    assign accept     = item_valid && item_ready;
    assign limit_ext  = CMP_W'(length_limit);

    // a new message starts from cleared state
    always_comb
    begin
        win_base    = start_reg ? '0 : win_reg;
        marker_base = start_reg ? '0 : marker_reg;
        danger_base = start_reg ? '0 : danger_reg;
        count_base  = start_reg ? '0 : count_reg;
        ended_base  = start_reg ? 1'b0 : ended_reg;
        if (!start_reg)
        begin
            limit_base = limit_reg;
        end
        else if (limit_ext > CMP_W'(LENGTH_MAX))
        begin
            limit_base = CNT_W'(LENGTH_MAX);
        end
        else
        begin
            limit_base = CNT_W'(limit_ext);
        end
    end

    always_comb
    begin
        for (int i = 0; i < MARK_N; i++)
        begin
            mark_hit[i] = tail_hit(win_base, text_byte, MARK_PAT[i], MARK_LEN[i], 1'b0);
        end
        for (int i = 0; i < DANGER_N; i++)
        begin
            danger_hit[i] = tail_hit(win_base, text_byte, DANGER_PAT[i], DANGER_LEN[i],
                                     1'b1);
        end
    end

    always_comb
    begin
        win_next    = win_reg;
        marker_next = marker_reg;
        danger_next = danger_reg;
        count_next  = count_reg;
        ended_next  = ended_reg;
        limit_next  = limit_reg;
        start_next  = start_reg;
        push        = 1'b0;
        if (accept)
        begin
            win_next    = win_base;
            marker_next = marker_base;
            danger_next = danger_base;
            count_next  = count_base;
            ended_next  = ended_base;
            limit_next  = limit_base;
            start_next  = last_item;
            push        = last_item;
            if (byte_present && !ended_base)
            begin
                if (text_byte == '0)
                begin
                    ended_next = 1'b1;
                end
                else
                begin
                    if (count_base < CNT_W'(LENGTH_MAX + 1))
                    begin
                        count_next = count_base + CNT_W'(1);
                    end
                    marker_next = marker_base | mark_hit;
                    danger_next = danger_base | danger_hit;
                    win_next    = {win_base[WIN_DEPTH-2:0], text_byte};
                end
            end
        end
        push_rec.count      = count_next;
        push_rec.limit      = limit_next;
        push_rec.marker_any = |marker_next;
        push_rec.danger     = danger_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg    <= '0;
            marker_reg <= '0;
            danger_reg <= '0;
            count_reg  <= '0;
            ended_reg  <= 1'b0;
            limit_reg  <= '0;
            start_reg  <= 1'b1;
        end
        else
        begin
            win_reg    <= win_next;
            marker_reg <= marker_next;
            danger_reg <= danger_next;
            count_reg  <= count_next;
            ended_reg  <= ended_next;
            limit_reg  <= limit_next;
            start_reg  <= start_next;
        end
    end

endmodule

// ===== rtl/xbps_queue.sv =====
// ----------------------------------------------------------------------------
// xbps_queue
// short register queue of finished message records
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xbps_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  xbps_pkg::rec_t    push_rec,
    input  logic              pop,
    output xbps_pkg::rec_t    head_rec,
    output xbps_pkg::q_stat_t q_stat
);
    import xbps_pkg::*;

    rec_t              slot_reg [Q_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg,    cnt_next;
    logic              do_push, do_pop;

    assign q_stat.full  = (cnt_reg == QCNT_W'(Q_DEPTH));
    assign q_stat.empty = (cnt_reg == '0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign head_rec     = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

// ===== rtl/xbps_back.sv =====
// ----------------------------------------------------------------------------
// xbps_back
// verdict decision and output register, one message record per beat while the output is free
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xbps_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  xbps_pkg::q_stat_t            q_stat,
    input  xbps_pkg::rec_t               head_rec,
    output logic                         pop,
    output logic                         result_valid,
    input  logic                         result_ready,
    output logic [1:0]                   verdict,
    output logic [xbps_pkg::IDX_W-1:0]   pattern_index,
    output logic [xbps_pkg::TEXT_W-1:0]  text_length
);
    import xbps_pkg::*;

    logic                valid_reg,   valid_next;
    logic [1:0]          verdict_reg, verdict_next;
    logic [IDX_W-1:0]    index_reg,   index_next;
    logic [TEXT_W-1:0]   length_reg;
    logic [IDX_W-1:0]    first_idx;
    logic                load;

    assign load = !q_stat.empty && (!valid_reg || result_ready);
    assign pop  = load;

    // lowest set danger flag wins
    always_comb
    begin
        first_idx = '0;
        for (int i = DANGER_N - 1; i >= 0; i--)
        begin
            if (head_rec.danger[i])
            begin
                first_idx = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        index_next = '0;
        if (head_rec.count > head_rec.limit)
        begin
            verdict_next = VERDICT_TOO_LONG;
        end
        else if (!head_rec.marker_any)
        begin
            verdict_next = VERDICT_NO_MARKER;
        end
        else if (head_rec.danger != '0)
        begin
            verdict_next = VERDICT_DANGER;
            index_next   = first_idx;
        end
        else
        begin
            verdict_next = VERDICT_OK;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            verdict_reg <= verdict_next;
            index_reg   <= index_next;
            length_reg  <= TEXT_W'(head_rec.count);
        end
    end

    assign result_valid  = valid_reg;
    assign verdict       = verdict_reg;
    assign pattern_index = index_reg;
    assign text_length   = length_reg;

endmodule

// ===== rtl/xml_body_pattern_screen_core.sv =====
// ----------------------------------------------------------------------------
// xml_body_pattern_screen_core
// Screens a message body that arrives one byte per beat and returns one
// verdict beat per message, on the beat marked last. A zero byte ends the
// text. The body is rejected as too long, then for lacking an xml or soap
// structure marker, then for containing a danger pattern (case-insensitive),
// in that order; for a danger pattern the first one in list order is
// reported. A new byte is accepted each cycle while the queue is not full:
// the front updates the 10-byte history, the count and the pattern flags as
// each byte is accepted, and a two-entry record queue lets the front keep
// going while a verdict waits at the output. A finished record passes the
// queue and then the output register. Input ready drops only when both queue
// entries hold messages whose verdicts have not yet been taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module xml_body_pattern_screen_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_ready,
    input  logic [xbps_pkg::BYTE_W-1:0]  text_byte,
    input  logic                         byte_present,
    input  logic [xbps_pkg::LIMIT_W-1:0] length_limit,
    input  logic                         last_item,
    output logic                         result_valid,
    input  logic                         result_ready,
    output logic [1:0]                   verdict,
    output logic [xbps_pkg::IDX_W-1:0]   pattern_index,
    output logic [xbps_pkg::TEXT_W-1:0]  text_length
);
    import xbps_pkg::*;

    q_stat_t q_stat;
    rec_t    push_rec;
    rec_t    head_rec;
    logic    push;
    logic    pop;

    xbps_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .text_byte    (text_byte),
        .byte_present (byte_present),
        .length_limit (length_limit),
        .last_item    (last_item),
        .q_stat       (q_stat),
        .push         (push),
        .push_rec     (push_rec)
    );

    xbps_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .head_rec (head_rec),
        .q_stat   (q_stat)
    );

    xbps_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_stat        (q_stat),
        .head_rec      (head_rec),
        .pop           (pop),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .verdict       (verdict),
        .pattern_index (pattern_index),
        .text_length   (text_length)
    );

    // assertions
    `ASSERT_CLK(a_index_only_on_danger, clk, rst_n, (result_valid && (verdict != VERDICT_DANGER)) |-> (pattern_index == '0), "pattern index set without danger verdict")
    `ASSERT_CLK(a_index_in_range, clk, rst_n, (result_valid && (verdict == VERDICT_DANGER)) |-> (pattern_index < IDX_W'(DANGER_N)), "pattern index out of range")
    `ASSERT_CLK(a_too_long_nonzero, clk, rst_n, (result_valid && (verdict == VERDICT_TOO_LONG)) |-> (text_length != '0), "too long verdict with empty text")
    `ASSERT_CLK(a_queue_status, clk, rst_n, !(q_stat.full && q_stat.empty), "queue both full and empty")

endmodule
